>>> sv/power_curve_color_ramp_defines.svh
// Assertion macros shared by the power curve color ramp RTL.
`ifndef POWER_CURVE_COLOR_RAMP_DEFINES_SVH
`define POWER_CURVE_COLOR_RAMP_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define PCR_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define PCR_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define PCR_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg)
`define PCR_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

>>> sv/pcr_pkg.sv
package pcr_pkg;

    // Fixed-point format of the log and exp domains.
    localparam int LOG_BITS = 28;
    localparam int M_W      = 32;
    localparam int P_W      = M_W + 8;
    localparam int IP_W     = P_W - LOG_BITS;

    // Defaults of the top-level parameters.
    localparam int RAMP_LENGTH_DEF = 256;
    localparam int WEIGHT_FRAC_DEF = 16;

    // Queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // Configuration port.
    localparam int ADDR_W = 5;
    localparam logic [15:0] EXP_RESET = 16'd256;

    typedef enum logic [2:0] {
        REG_AMBIENT      = 3'd0,
        REG_FIRST_COLOR  = 3'd1,
        REG_SECOND_COLOR = 3'd2,
        REG_FIRST_EXP    = 3'd3,
        REG_SECOND_EXP   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [23:0] ambient_color;
        logic [23:0] first_color;
        logic [23:0] second_color;
        logic [15:0] first_exponent;
        logic [15:0] second_exponent;
    } t_cfg;

    // One classified item: scaled logs of both weights and special-case flags.
    typedef struct packed {
        logic [7:0]     idx;
        logic           nz;
        logic           e1z;
        logic           e2z;
        logic [P_W-1:0] p1;
        logic [P_W-1:0] p2;
    } t_q_entry;

    typedef struct packed {
        logic     valid;
        t_q_entry entry;
    } t_q_wr;

    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
        logic               empty;
    } t_q_status;

    // Integer square root, used only at elaboration.
    function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] bt;
        v  = v_in;
        r  = '0;
        bt = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= r + bt) begin
                v = v - (r + bt);
                r = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return r;
    endfunction

    // The 2^k-th root of two in Q.LOG_BITS, used only at elaboration.
    function automatic logic [63:0] root_of(input int k);
        logic [63:0] r;
        r = 64'd2 << LOG_BITS;
        for (int j = 1; j <= k; j++) r = int_sqrt(r << LOG_BITS);
        return r;
    endfunction

    // log2 of an integer with LOG_BITS fraction bits by repeated squaring.
    function automatic logic [63:0] log2_q(input logic [63:0] n);
        int unsigned k;
        logic [63:0] x;
        logic [63:0] frac;
        k    = 0;
        frac = '0;
        while (k < 40 && (n >> (k + 1)) != 0) k++;
        x = (k <= LOG_BITS) ? (n << (LOG_BITS - k)) : (n >> (k - LOG_BITS));
        for (int b = 0; b < LOG_BITS; b++) begin
            x    = (x * x) >> LOG_BITS;
            frac = {frac[62:0], 1'b0};
            if (x >= (64'd2 << LOG_BITS)) begin
                frac[0] = 1'b1;
                x       = x >> 1;
            end
        end
        return (64'(k) << LOG_BITS) | frac;
    endfunction

    // Negative log2 of the base for one ramp index.
    function automatic logic [M_W-1:0] m_of(input logic [63:0] rl, input logic [63:0] i);
        logic [63:0] la;
        logic [63:0] ln;
        if (i >= rl) return '0;
        la = log2_q(rl);
        ln = log2_q(rl - i);
        return (la > ln) ? M_W'(la - ln) : '0;
    endfunction

endpackage

>>> sv/pcr_in_if.sv
interface pcr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ramp_index;

    modport source (output valid, output ramp_index, input ready);
    modport sink (input valid, input ramp_index, output ready);
endinterface

>>> sv/pcr_out_if.sv
interface pcr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output entry_index, output red, output green,
                    output blue, input ready);
    modport sink (input valid, input entry_index, input red, input green,
                  input blue, output ready);
endinterface

>>> sv/pcr_queue.sv
`include "power_curve_color_ramp_defines.svh"

module pcr_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pcr_pkg::t_q_wr      i_wr,
    input  logic                i_pop,
    output pcr_pkg::t_q_entry   o_rd,
    output pcr_pkg::t_q_status  o_stat
);
    import pcr_pkg::*;

    t_q_entry           r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_CNT_W-1:0] r_cnt;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr.valid) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + Q_CNT_W'(i_wr.valid) - Q_CNT_W'(i_pop);
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_wr.valid) r_mem[r_wp] <= i_wr.entry;
    end

    assign o_rd         = r_mem[r_rp];
    assign o_stat.count = r_cnt;
    assign o_stat.empty = (r_cnt == '0);

    `PCR_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_wr.valid, r_cnt != Q_CNT_W'(Q_DEPTH), "queue written while full")
    `PCR_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, i_pop, r_cnt != '0, "queue read while empty")
    `PCR_ASSERT_IMPL(a_ptr_match, i_clk, i_rst_n, r_cnt == '0, r_wp == r_rp, "pointers differ on empty queue")
endmodule

>>> sv/pcr_front.sv
module pcr_front #(
    parameter int RAMP_LENGTH = pcr_pkg::RAMP_LENGTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pcr_in_if.sink             i_ramp,
    input  pcr_pkg::t_cfg      i_cfg,
    input  pcr_pkg::t_q_status i_q_stat,
    output pcr_pkg::t_q_wr     o_wr
);
    import pcr_pkg::*;

    localparam int IDX_N = 256;

    logic [M_W-1:0]      w_tab [IDX_N];
    logic                r_v1;
    logic                r_v2;
    logic [7:0]          r_idx1;
    logic [7:0]          r_idx2;
    logic [M_W-1:0]      r_m2;
    logic                r_nz2;
    logic [Q_CNT_W:0]    w_load;
    logic                w_acc;
    logic [M_W+15:0]     w_prod1;
    logic [M_W+15:0]     w_prod2;

    // Negative log2 of the base for every index, fixed at elaboration.
    for (genvar gi = 0; gi < IDX_N; gi++) begin : g_tab
        localparam logic [M_W-1:0] M_VAL = m_of(64'(RAMP_LENGTH), 64'(gi));
        assign w_tab[gi] = M_VAL;
    end

    // Take a transfer only if the queue holds room for everything in flight.
    assign w_load = {1'b0, i_q_stat.count} + (Q_CNT_W+1)'(r_v1) + (Q_CNT_W+1)'(r_v2);
    assign i_ramp.ready = (w_load < (Q_CNT_W+1)'(Q_DEPTH));
    assign w_acc = i_ramp.valid && i_ramp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= w_acc;
            r_v2 <= r_v1;
        end
    end

    // Index capture, then table lookup and base-zero check.
    always_ff @(posedge i_clk) begin
        if (w_acc) r_idx1 <= i_ramp.ramp_index;
        r_idx2 <= r_idx1;
        r_m2   <= w_tab[r_idx1];
        r_nz2  <= (32'(r_idx1) >= 32'(RAMP_LENGTH));
    end

    // Scale the log by each exponent (Q8.8), result goes into the queue.
    assign w_prod1 = {16'd0, r_m2} * {{M_W{1'b0}}, i_cfg.first_exponent};
    assign w_prod2 = {16'd0, r_m2} * {{M_W{1'b0}}, i_cfg.second_exponent};

    assign o_wr.valid     = r_v2;
    assign o_wr.entry.idx = r_idx2;
    assign o_wr.entry.nz  = r_nz2;
    assign o_wr.entry.e1z = (i_cfg.first_exponent == '0);
    assign o_wr.entry.e2z = (i_cfg.second_exponent == '0);
    assign o_wr.entry.p1  = w_prod1[M_W+15:8];
    assign o_wr.entry.p2  = w_prod2[M_W+15:8];
endmodule

>>> sv/pcr_back.sv
`include "power_curve_color_ramp_defines.svh"

module pcr_back #(
    parameter int WEIGHT_FRACTION_BITS = pcr_pkg::WEIGHT_FRAC_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pcr_pkg::t_q_entry  i_q_data,
    input  pcr_pkg::t_q_status i_q_stat,
    output logic               o_pop,
    input  pcr_pkg::t_cfg      i_cfg,
    pcr_out_if.source          o_entry
);
    import pcr_pkg::*;

    localparam int F     = WEIGHT_FRACTION_BITS;
    localparam int W_W   = F + 1;
    localparam int SUM_W = F + 10;
    localparam logic [W_W-1:0] W_ONE = {1'b1, {F{1'b0}}};
    localparam logic [IP_W+1:0] SH_BASE = (IP_W+2)'(LOG_BITS - F);

    typedef struct packed {
        logic [LOG_BITS:0]   mant;
        logic [LOG_BITS-1:0] g;
        logic [IP_W:0]       sh;
    } t_lane;

    typedef struct packed {
        logic [7:0] idx;
        logic       nz;
        logic       e1z;
        logic       e2z;
        t_lane      l1;
        t_lane      l2;
    } t_stage;

    logic       r_sv [0:LOG_BITS];
    t_stage     r_st [0:LOG_BITS];
    logic       w_adv;
    logic       r_wv;
    logic [7:0] r_widx;
    logic       r_wnz;
    logic       r_we1z;
    logic [W_W-1:0] r_w1;
    logic [W_W-1:0] r_w2;
    logic       r_ov;
    logic [7:0] r_oidx;
    logic [7:0] r_ored;
    logic [7:0] r_ogrn;
    logic [7:0] r_oblu;

    // Split the scaled log into shift and exp2 argument.
    function automatic t_lane lane_init(input logic [P_W-1:0] p);
        t_lane               r;
        logic [LOG_BITS-1:0] fp;
        fp     = p[LOG_BITS-1:0];
        r.mant = {1'b1, {LOG_BITS{1'b0}}};
        r.g    = ~fp + 1'b1;
        r.sh   = {1'b0, p[P_W-1:LOG_BITS]} + (IP_W+1)'(fp != '0);
        return r;
    endfunction

    // Final weight from mantissa and shift, with the zero-base case.
    function automatic logic [W_W-1:0] weight(input t_lane ln, input logic nz,
                                              input logic ez);
        logic [IP_W+1:0]   total;
        logic [LOG_BITS:0] sft;
        total = {1'b0, ln.sh} + SH_BASE;
        sft   = ln.mant >> total;
        if (nz) return ez ? W_ONE : '0;
        return sft[W_W-1:0];
    endfunction

    // One color channel: weighted sum, saturate, ambient add, saturate.
    function automatic logic [7:0] chan(input logic [7:0] c1, input logic [7:0] c2,
                                        input logic [7:0] amb, input logic [W_W-1:0] w1,
                                        input logic [W_W-1:0] w2);
        logic [SUM_W-1:0] s;
        logic [9:0]       v;
        logic [7:0]       vs;
        logic [8:0]       t;
        s  = SUM_W'(c1) * SUM_W'(w1) + SUM_W'(c2) * SUM_W'(w2);
        v  = s[SUM_W-1:F];
        vs = (v > 10'd255) ? 8'hFF : v[7:0];
        t  = {1'b0, vs} + {1'b0, amb};
        return t[8] ? 8'hFF : t[7:0];
    endfunction

    // The whole back pipeline moves when the output register can take data.
    assign w_adv = !r_ov || o_entry.ready;
    assign o_pop = w_adv && !i_q_stat.empty;

    // Entry stage: pop from the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (w_adv) begin
            r_sv[0] <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_st[0].idx <= i_q_data.idx;
            r_st[0].nz  <= i_q_data.nz;
            r_st[0].e1z <= i_q_data.e1z;
            r_st[0].e2z <= i_q_data.e2z;
            r_st[0].l1  <= lane_init(i_q_data.p1);
            r_st[0].l2  <= lane_init(i_q_data.p2);
        end
    end

    // exp2 by successive roots of two, one root per stage.
    for (genvar k = 1; k <= LOG_BITS; k++) begin : g_exp
        localparam logic [LOG_BITS:0] ROOT = (LOG_BITS+1)'(root_of(k));
        logic [2*LOG_BITS+1:0] w_prod1;
        logic [2*LOG_BITS+1:0] w_prod2;
        t_stage                n_st;

        assign w_prod1 = r_st[k-1].l1.mant * ROOT;
        assign w_prod2 = r_st[k-1].l2.mant * ROOT;

        always_comb begin
            n_st = r_st[k-1];
            if (r_st[k-1].l1.g[LOG_BITS-k]) n_st.l1.mant = w_prod1[2*LOG_BITS:LOG_BITS];
            if (r_st[k-1].l2.g[LOG_BITS-k]) n_st.l2.mant = w_prod2[2*LOG_BITS:LOG_BITS];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k] <= 1'b0;
            end else if (w_adv) begin
                r_sv[k] <= r_sv[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) r_st[k] <= n_st;
        end
    end

    // Weight stage and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_wv <= r_sv[LOG_BITS];
            r_ov <= r_wv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_widx <= r_st[LOG_BITS].idx;
            r_wnz  <= r_st[LOG_BITS].nz;
            r_we1z <= r_st[LOG_BITS].e1z;
            r_w1   <= weight(r_st[LOG_BITS].l1, r_st[LOG_BITS].nz, r_st[LOG_BITS].e1z);
            r_w2   <= weight(r_st[LOG_BITS].l2, r_st[LOG_BITS].nz, r_st[LOG_BITS].e2z);
            r_oidx <= r_widx;
            r_ored <= chan(i_cfg.first_color[23:16], i_cfg.second_color[23:16],
                           i_cfg.ambient_color[23:16], r_w1, r_w2);
            r_ogrn <= chan(i_cfg.first_color[15:8], i_cfg.second_color[15:8],
                           i_cfg.ambient_color[15:8], r_w1, r_w2);
            r_oblu <= chan(i_cfg.first_color[7:0], i_cfg.second_color[7:0],
                           i_cfg.ambient_color[7:0], r_w1, r_w2);
        end
    end

    assign o_entry.valid       = r_ov;
    assign o_entry.entry_index = r_oidx;
    assign o_entry.red         = r_ored;
    assign o_entry.green       = r_ogrn;
    assign o_entry.blue        = r_oblu;

    `PCR_ASSERT_IMPL(a_zero_base, i_clk, i_rst_n, r_wv && r_wnz && !r_we1z, r_w1 == '0, "nonzero weight on zero base")
    `PCR_ASSERT_IMPL(a_weight_max, i_clk, i_rst_n, r_wv, r_w1 <= W_ONE && r_w2 <= W_ONE, "weight above one")
    `PCR_ASSERT_IMPL(a_out_src, i_clk, i_rst_n, $rose(r_ov), $past(r_wv), "output valid without weight stage")
endmodule

>>> sv/power_curve_color_ramp.sv
// Power curve color ramp: turns a ramp index into one RGB ramp entry.
// Input channel i_ramp carries ramp_index; output channel o_entry carries
// entry_index (the echoed index) and the red, green and blue channels.
// Both use valid/ready; a transfer happens when valid and ready are high.
// Colors and exponents are set through the APB port (psel, penable, ...),
// register i at byte address 4*i, written only while the block is idle;
// the user must keep to this, the block does not enforce it. From input
// transfer to output valid, the index is captured at the transfer, then
// passes a front register for the log lookup, the queue and a 31-stage
// back pipeline: split stage, 28 exp2 root stages, weight stage, output
// register. Throughput is one entry per cycle; the front stops taking
// transfers when the four-entry queue would overflow.
// When the receiver stalls, the back pipeline holds in place, the queue
// fills and then i_ramp.ready drops.
// Reset clears all valid state and loads the register defaults: colors 0,
// both exponents 1.0. No clearing pass is needed.
module power_curve_color_ramp #(
    parameter int RAMP_LENGTH          = pcr_pkg::RAMP_LENGTH_DEF,
    parameter int WEIGHT_FRACTION_BITS = pcr_pkg::WEIGHT_FRAC_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    pcr_in_if.sink                     i_ramp,
    pcr_out_if.source                  o_entry,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pcr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import pcr_pkg::*;

    t_cfg      r_cfg;
    t_reg_idx  w_reg;
    t_q_wr     w_wr;
    t_q_entry  w_rd;
    t_q_status w_stat;
    logic      w_pop;

    assign w_reg  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign pready = 1'b1;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ambient_color   <= '0;
            r_cfg.first_color     <= '0;
            r_cfg.second_color    <= '0;
            r_cfg.first_exponent  <= EXP_RESET;
            r_cfg.second_exponent <= EXP_RESET;
        end else if (psel && penable && pwrite) begin
            case (w_reg)
                REG_AMBIENT:      r_cfg.ambient_color   <= pwdata[23:0];
                REG_FIRST_COLOR:  r_cfg.first_color     <= pwdata[23:0];
                REG_SECOND_COLOR: r_cfg.second_color    <= pwdata[23:0];
                REG_FIRST_EXP:    r_cfg.first_exponent  <= pwdata[15:0];
                REG_SECOND_EXP:   r_cfg.second_exponent <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (w_reg)
            REG_AMBIENT:      prdata = {8'd0, r_cfg.ambient_color};
            REG_FIRST_COLOR:  prdata = {8'd0, r_cfg.first_color};
            REG_SECOND_COLOR: prdata = {8'd0, r_cfg.second_color};
            REG_FIRST_EXP:    prdata = {16'd0, r_cfg.first_exponent};
            REG_SECOND_EXP:   prdata = {16'd0, r_cfg.second_exponent};
            default:          prdata = '0;
        endcase
    end

    pcr_front #(
        .RAMP_LENGTH (RAMP_LENGTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ramp   (i_ramp),
        .i_cfg    (r_cfg),
        .i_q_stat (w_stat),
        .o_wr     (w_wr)
    );

    pcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_pop   (w_pop),
        .o_rd    (w_rd),
        .o_stat  (w_stat)
    );

    pcr_back #(
        .WEIGHT_FRACTION_BITS (WEIGHT_FRACTION_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_data (w_rd),
        .i_q_stat (w_stat),
        .o_pop    (w_pop),
        .i_cfg    (r_cfg),
        .o_entry  (o_entry)
    );
endmodule
